// ----- design/adpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants for the DSP ADPCM stream decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

  // one byte of the encoded stream
  typedef struct packed {
    logic       block_start;
    logic [7:0] data_byte;
  } in_item_t;

  // both samples decoded from one data byte
  typedef struct packed {
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
  } out_item_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;    // capture coefficient times history
    logic load_base; // start a new sum with the scaled delta
    logic add_prod;  // add the captured product
  } mac_ctrl_t;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_01   = 3'd0;
  localparam logic [2:0] REG_COEF_23   = 3'd1;
  localparam logic [2:0] REG_COEF_45   = 3'd2;
  localparam logic [2:0] REG_COEF_67   = 3'd3;
  localparam logic [2:0] REG_INIT_HIST = 3'd4;

  localparam int NUM_COEF_REGS = 4;
  localparam int CFG_AW        = 6;
  localparam int CFG_DW        = 64;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 34;
  localparam int FRAC_SH  = 11;
  localparam int Q_W      = ACC_W - FRAC_SH;

  localparam logic signed [ACC_W-1:0]    ROUND_BIAS = ACC_W'(1024);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// ----- design/adpcm_mac.sv -----
// ----------------------------------------------------------------------------
// adpcm_mac
// Shared multiply-accumulate unit: one 16x16 product per cycle, a 34-bit
// accumulator, and floor shift with saturation to a 16-bit sample.
// ----------------------------------------------------------------------------
module adpcm_mac (
  input  logic                     clk,
  input  adpcm_pkg::mac_ctrl_t     ctrl,
  input  logic [3:0]               nibble,
  input  logic [3:0]               scale,
  input  logic signed [15:0]       coef,
  input  logic signed [15:0]       hist,
  output logic signed [15:0]       sample
);

  logic signed [31:0]                 prod_r;
  logic signed [adpcm_pkg::ACC_W-1:0] acc_r;
  logic signed [adpcm_pkg::ACC_W-1:0] delta_ext;
  logic signed [adpcm_pkg::ACC_W-1:0] base;
  logic [4:0]                         shamt;
  logic signed [adpcm_pkg::Q_W-1:0]   q;

  assign delta_ext = {{(adpcm_pkg::ACC_W-4){nibble[3]}}, nibble};
  assign shamt     = {1'b0, scale} + 5'd11;
  assign base      = (delta_ext <<< shamt) + adpcm_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * hist;
    end
    if (ctrl.load_base) begin
      acc_r <= base;
    end else if (ctrl.add_prod) begin
      acc_r <= acc_r + {{(adpcm_pkg::ACC_W-32){prod_r[31]}}, prod_r};
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign q = adpcm_pkg::Q_W'(acc_r >>> adpcm_pkg::FRAC_SH);

  always_comb begin
    if (!q[adpcm_pkg::Q_W-1] && (q[adpcm_pkg::Q_W-2:15] != '0)) begin
      sample = adpcm_pkg::SAMPLE_MAX;
    end else if (q[adpcm_pkg::Q_W-1] && (q[adpcm_pkg::Q_W-2:15] != '1)) begin
      sample = adpcm_pkg::SAMPLE_MIN;
    end else begin
      sample = q[15:0];
    end
  end

endmodule

// ----- design/dsp_adpcm_decoder_top.sv -----
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder_top
// Decodes 8-byte ADPCM frames, one byte per item, into pairs of samples.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   in_      | input     | in_valid/in_stall  | data_byte, block_start
//   out_     | output    | out_valid/out_stall| sample_first, sample_second
//   config   | input     | apb psel/penable   | coefficients, history
//
// a header byte is taken without leaving idle and gives no result
// a data byte is accepted, then each nibble takes 4 steps through the
// one shared 16x16 multiplier (two products, two adds, shift and saturate)
// the finished item sits in the output register; the next item is taken
// meanwhile, and a second result waits in the saturate step while it stalls
// synchronous active-low reset clears state, configuration, history and frame position
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  adpcm_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output adpcm_pkg::out_item_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adpcm_pkg::CFG_AW-1:0]      paddr,
  input  logic [adpcm_pkg::CFG_DW-1:0]      pwdata,
  output logic [adpcm_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL1  = 5'b00010,
    ST_MUL2  = 5'b00100,
    ST_ACCUM = 5'b01000,
    ST_SAT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0]        coef_r [adpcm_pkg::NUM_COEF_REGS];
  logic [31:0]        init_hist_r;
  logic signed [15:0] hist1_r, hist2_r;
  logic [3:0]         scale_r;
  logic [2:0]         pred_r;
  logic [2:0]         frame_r;
  logic [7:0]         byte_r;
  logic               second_r;
  logic signed [15:0] first_r;
  logic               out_valid_r;
  adpcm_pkg::out_item_t out_data_r;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               in_acc;
  logic               is_header;
  logic               slot_free;
  logic [3:0]         cidx;
  logic [63:0]        coef_word;
  logic signed [15:0] coef_sel;
  logic signed [15:0] hist_sel;
  logic [3:0]         nibble;
  logic signed [15:0] sample;
  adpcm_pkg::mac_ctrl_t mac_ctrl;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[adpcm_pkg::CFG_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      adpcm_pkg::REG_COEF_01:   prdata = coef_r[0];
      adpcm_pkg::REG_COEF_23:   prdata = coef_r[1];
      adpcm_pkg::REG_COEF_45:   prdata = coef_r[2];
      adpcm_pkg::REG_COEF_67:   prdata = coef_r[3];
      adpcm_pkg::REG_INIT_HIST: prdata = {32'd0, init_hist_r};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < adpcm_pkg::NUM_COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
      init_hist_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        adpcm_pkg::REG_COEF_01:   coef_r[0] <= pwdata;
        adpcm_pkg::REG_COEF_23:   coef_r[1] <= pwdata;
        adpcm_pkg::REG_COEF_45:   coef_r[2] <= pwdata;
        adpcm_pkg::REG_COEF_67:   coef_r[3] <= pwdata;
        adpcm_pkg::REG_INIT_HIST: init_hist_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_header = in_data.block_start || (frame_r == 3'd0);
  assign slot_free = !out_valid_r || !out_stall;

  // operand selection for the shared unit: c1*h1 first, then c2*h2
  assign cidx      = {pred_r, (state_r == ST_MUL2)};
  assign coef_word = coef_r[cidx[3:2]];
  assign coef_sel  = coef_word[{cidx[1:0], 4'd0} +: 16];
  assign hist_sel  = (state_r == ST_MUL2) ? hist2_r : hist1_r;
  assign nibble    = second_r ? byte_r[3:0] : byte_r[7:4];

  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.mul_en    = (state_r == ST_MUL1) || (state_r == ST_MUL2);
    mac_ctrl.load_base = (state_r == ST_MUL1);
    mac_ctrl.add_prod  = (state_r == ST_MUL2) || (state_r == ST_ACCUM);
  end

  adpcm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .nibble (nibble),
    .scale  (scale_r),
    .coef   (coef_sel),
    .hist   (hist_sel),
    .sample (sample)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && !is_header) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = ST_SAT;
      ST_SAT: begin
        if (!second_r) begin
          state_nxt = ST_MUL1;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist1_r     <= '0;
      hist2_r     <= '0;
      scale_r     <= '0;
      pred_r      <= '0;
      frame_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new item may replace the one leaving in the same cycle
      if ((state_r == ST_SAT) && second_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.block_start) begin
              hist1_r <= init_hist_r[31:16];
              hist2_r <= init_hist_r[15:0];
            end
            if (is_header) begin
              scale_r <= in_data.data_byte[3:0];
              pred_r  <= in_data.data_byte[6:4];
              frame_r <= 3'd1;
            end else begin
              frame_r  <= frame_r + 3'd1;
              second_r <= 1'b0;
            end
          end
        end
        ST_SAT: begin
          if (!second_r) begin
            hist2_r  <= hist1_r;
            hist1_r  <= sample;
            second_r <= 1'b1;
          end else if (slot_free) begin
            hist2_r <= hist1_r;
            hist1_r <= sample;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_data.data_byte;
    end
    if ((state_r == ST_SAT) && !second_r) begin
      first_r <= sample;
    end
    if ((state_r == ST_SAT) && second_r && slot_free) begin
      out_data_r.sample_first  <= first_r;
      out_data_r.sample_second <= sample;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/adpcm_chk.sv -----
// ----------------------------------------------------------------------------
// adpcm_chk
// Port-level checks for the ADPCM decoder, bound to the top level.
// ----------------------------------------------------------------------------
module adpcm_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input adpcm_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input adpcm_pkg::out_item_t out_data
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // block start is always a header, so the input is free again in the next cycle
  a_start_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.block_start |=> !in_stall)
    else $error("block start byte did not finish in one cycle");

  // a new result only appears at the end of decode work
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without decode work");

  // reset leaves both channels quiet
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not idle after reset");

endmodule

bind dsp_adpcm_decoder_top adpcm_chk u_adpcm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/dsp_adpcm_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder_top_tb
// Drives ADPCM frames into the decoder and checks each decoded sample pair
// against an in-bench predictor. Runs several coefficient and history setups,
// with random gaps on both channels, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_top_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 170;

  // predictor of the decoder plus the queue of sample pairs still owed
  class decoded_sample_checker;
    logic [63:0]        coef_word[adpcm_pkg::NUM_COEF_REGS];
    logic [31:0]        start_history;
    logic signed [15:0] prev_one;
    logic signed [15:0] prev_two;
    logic [3:0]         scale;
    logic [2:0]         pair_sel;
    logic [2:0]         frame_pos;
    adpcm_pkg::out_item_t pending_samples[$];
    int                 errors;

    function new();
      foreach (coef_word[k]) coef_word[k] = '0;
      start_history = '0;
      prev_one = '0;
      prev_two = '0;
      scale = '0;
      pair_sel = '0;
      frame_pos = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        adpcm_pkg::REG_COEF_01, adpcm_pkg::REG_COEF_23,
        adpcm_pkg::REG_COEF_45, adpcm_pkg::REG_COEF_67: begin
          coef_word[idx] = val;
        end
        adpcm_pkg::REG_INIT_HIST: begin
          start_history = val[31:0];
        end
        default: ;
      endcase
    endfunction

    function longint coef_of(logic [3:0] i);
      logic [63:0]        w;
      logic signed [15:0] v;
      w = coef_word[i[3:2]];
      v = w[16*i[1:0] +: 16];
      return v;
    endfunction

    function logic signed [15:0] nibble_to_sample(logic [3:0] nib);
      longint delta;
      longint acc;
      logic signed [15:0] s;
      delta = nib[3] ? longint'(nib) - 16 : longint'(nib);
      acc = (delta <<< (scale + 11)) + coef_of({pair_sel, 1'b0}) * prev_one
          + coef_of({pair_sel, 1'b1}) * prev_two + 1024;
      acc = acc >>> 11;
      if (acc > 32767) s = 16'sh7FFF;
      else if (acc < -32768) s = 16'sh8000;
      else s = acc[15:0];
      prev_two = prev_one;
      prev_one = s;
      return s;
    endfunction

    function void take_byte(adpcm_pkg::in_item_t it);
      adpcm_pkg::out_item_t pair;
      if (it.block_start) begin
        prev_one = start_history[31:16];
        prev_two = start_history[15:0];
        frame_pos = '0;
      end
      if (frame_pos == 0) begin
        scale = it.data_byte[3:0];
        pair_sel = it.data_byte[6:4];
        frame_pos = 3'd1;
      end else begin
        pair.sample_first = nibble_to_sample(it.data_byte[7:4]);
        pair.sample_second = nibble_to_sample(it.data_byte[3:0]);
        frame_pos = frame_pos + 3'd1;
        pending_samples.push_back(pair);
      end
    endfunction

    function void check_samples(adpcm_pkg::out_item_t got);
      adpcm_pkg::out_item_t want;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample pair %0d %0d", got.sample_first, got.sample_second);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (got.sample_first !== want.sample_first) begin
        $error("sample_first: expected %0d, actual %0d", want.sample_first, got.sample_first);
        errors++;
      end
      if (got.sample_second !== want.sample_second) begin
        $error("sample_second: expected %0d, actual %0d",
               want.sample_second, got.sample_second);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  adpcm_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  adpcm_pkg::out_item_t out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [adpcm_pkg::CFG_AW-1:0] paddr = '0;
  logic [adpcm_pkg::CFG_DW-1:0] pwdata = '0;
  logic [adpcm_pkg::CFG_DW-1:0] prdata;
  logic                 pready;

  decoded_sample_checker dec_model = new();

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;

  dsp_adpcm_decoder_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted pairs, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) dec_model.check_samples(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // back-to-back writes go straight from access to the next setup cycle
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dec_model.set_reg(idx, val);
  endtask

  task automatic load_setup(logic [63:0] c01, logic [63:0] c23, logic [63:0] c45,
                            logic [63:0] c67, logic [31:0] hist);
    write_reg(adpcm_pkg::REG_COEF_01, c01);
    write_reg(adpcm_pkg::REG_COEF_23, c23);
    write_reg(adpcm_pkg::REG_COEF_45, c45);
    write_reg(adpcm_pkg::REG_COEF_67, c67);
    write_reg(adpcm_pkg::REG_INIT_HIST, {32'h0, hist});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // four coefficients in the range -4096 to 4095
  function automatic logic [63:0] plausible_coefs();
    logic [63:0] w;
    for (int j = 0; j < 4; j++) w[16*j +: 16] = 16'($urandom_range(8191)) - 16'd4096;
    return w;
  endfunction

  function automatic logic [63:0] any_coefs();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(logic start, logic [7:0] b);
    adpcm_pkg::in_item_t it;
    it.block_start = start;
    it.data_byte = b;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dec_model.take_byte(it);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (dec_model.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random stream; frames line up on their own, block starts land anywhere
  task automatic run_stream(int n, int tx_pct, int rx_pct, bit long_hold, bit mid_pause);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 2) hold_req <= ~hold_req;
      if (mid_pause && i == n / 3) wait_drain();
      send_byte($urandom_range(15) == 0, 8'($urandom_range(255)));
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pair 0 is (1.0, -1.0), pair 1 the largest magnitudes,
    // pair 6 most negative, pair 7 most positive
    load_setup(64'h8000_7FFF_F800_0800, plausible_coefs(), 64'h0,
               64'h7FFF_7FFF_8000_8000, 32'h7FFF_8000);

    // header at power-up without block start, then largest scale both signs
    send_byte(1'b0, 8'h0F);
    send_byte(1'b0, 8'h78);
    // block start mid-frame, predictor bit 7 set
    send_byte(1'b1, 8'h90);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h08);
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, 8'hEE);
    send_byte(1'b0, 8'h7F);
    // frame end, header follows without block start
    send_byte(1'b0, 8'hE4);
    send_byte(1'b0, 8'h12);
    send_byte(1'b0, 8'h34);
    send_byte(1'b0, 8'h56);
    send_byte(1'b0, 8'h78);
    send_byte(1'b0, 8'h9A);
    send_byte(1'b0, 8'hBC);
    send_byte(1'b0, 8'hDE);
    send_byte(1'b1, 8'hAF);
    send_byte(1'b0, 8'hF0);
    send_byte(1'b0, 8'h0F);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h55);
    wait_drain();

    load_setup(plausible_coefs(), plausible_coefs(), plausible_coefs(),
               plausible_coefs(), $urandom);
    run_stream(SEG_ITEMS, 16, 59, 1'b1, 1'b0);

    load_setup({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h8000}},
               32'h8000_7FFF);
    run_stream(SEG_ITEMS, 59, 16, 1'b0, 1'b1);

    load_setup(64'h0, 64'h0, 64'h0, 64'h0, 32'h0);
    run_stream(SEG_ITEMS, 0, 0, 1'b0, 1'b0);

    load_setup(any_coefs(), any_coefs(), any_coefs(), any_coefs(), $urandom);
    run_stream(SEG_ITEMS, 0, 0, 1'b0, 1'b0);

    if (dec_model.errors == 0 && dec_model.pending_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- dsp_adpcm_decoder_top.f -----
design/adpcm_pkg.sv
design/adpcm_mac.sv
design/dsp_adpcm_decoder_top.sv
design/adpcm_chk.sv
tb/dsp_adpcm_decoder_top_tb.sv
